/* rtl/exact_k_distinct_window_counter_defines.svh */
// Assertion helpers used by the checker file.
`ifndef EXACT_K_DISTINCT_WINDOW_COUNTER_DEFINES_SVH
`define EXACT_K_DISTINCT_WINDOW_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EKDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EKDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ekdw_pkg.sv */
package ekdw_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DISTINCT_DEF = 16;
  localparam int MAX_LENGTH_DEF   = 1048575;
  localparam int NAME_BITS_DEF    = 32;

  // Fixed port widths
  localparam int NAME_CODE_W = 32;
  localparam int TOTAL_W     = 48;
  localparam int TARGET_W    = 5;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd1;

  // Per-request flags that travel with it down the pipeline
  typedef struct packed {
    logic last;     // final request of the sequence
    logic pos_ovf;  // position saturated somewhere in this sequence
  } item_flags_t;

endpackage

/* rtl/exact_k_distinct_window_counter.sv */
// Counts contiguous runs holding exactly k distinct names over a stream.
// Input channel: in_valid_i / in_stall_o carry name_code_i and last_item_i.
// Output channel: out_valid_o / out_stall_i carry running_total_o,
//   total_final_o and overflow_o; one result per accepted request.
// Config channel: cfg_valid_i / cfg_ready_o write k (cfg_data_i), always
//   ready; write only while no request is in flight. Zero acts as 1, values
//   above MAX_DISTINCT act as MAX_DISTINCT.
// Pipeline: table and position pick, difference, accumulate; each stage
//   is registered, and a result follows its request through all three.
// Throughput: one request per cycle while no stalled result holds the
//   pipeline; the table of MAX_DISTINCT+1 cells searches and shifts as the
//   request is taken, then difference and accumulate stages follow.
// Stall: the three stages move together; while a result waits under
//   out_stall_i, in_stall_o is high and everything holds.
// Reset (rst_ni low, asynchronous) empties the table, clears position,
//   total and overflow, and sets k to 1. The same clearing happens after
//   the request marked last_item_i; k keeps its value.
module exact_k_distinct_window_counter
  import ekdw_pkg::*;
#(
  parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
  parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
  parameter int NAME_BITS    = NAME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NAME_CODE_W-1:0] name_code_i,
  input  logic                   last_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [TOTAL_W-1:0]     running_total_o,
  output logic                   total_final_o,
  output logic                   overflow_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [TARGET_W-1:0]    cfg_data_i
);

  localparam int DEPTH = MAX_DISTINCT + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int KW    = (IDX_W > TARGET_W) ? IDX_W : TARGET_W;
  localparam int KEY_W = (NAME_BITS < NAME_CODE_W) ? NAME_BITS : NAME_CODE_W;
  localparam int POS_W = $clog2(MAX_LENGTH + 1);

  logic [TARGET_W-1:0] target_q;
  logic [KW-1:0]       k_ext;
  logic [KW-1:0]       k_cl;
  logic [IDX_W-1:0]    slot_hi;
  logic [IDX_W-1:0]    slot_lo;

  logic                adv;
  logic                accept;
  logic [KEY_W-1:0]    key;

  logic [POS_W-1:0]    pos_q;
  logic                pos_ovf_q;
  logic                pos_sat;
  logic [POS_W-1:0]    pos_new;

  logic                s1_valid_q;
  item_flags_t         s1_flags_q;

  logic [KEY_W-1:0]    name_c  [DEPTH+1];
  logic [POS_W-1:0]    pos_c   [DEPTH+1];
  logic                valid_c [DEPTH+1];
  logic                found_c [DEPTH+1];
  logic [POS_W-1:0]    nxt_pos [DEPTH];

  logic [POS_W-1:0]    pk;
  logic [POS_W-1:0]    pk1;
  logic [POS_W-1:0]    pk_q;
  logic [POS_W-1:0]    pk1_q;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  // Clamp k into 1..MAX_DISTINCT
  always_comb begin
    k_ext = KW'(target_q);
    if (k_ext == '0) begin
      k_cl = KW'(1);
    end else if (k_ext > KW'(MAX_DISTINCT)) begin
      k_cl = KW'(MAX_DISTINCT);
    end else begin
      k_cl = k_ext;
    end
  end

  assign slot_hi = k_cl[IDX_W-1:0];
  assign slot_lo = slot_hi - IDX_W'(1);

  // Handshake: all stages advance unless a result sits stalled
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign key        = name_code_i[KEY_W-1:0];

  // Position counter, saturating at MAX_LENGTH
  assign pos_sat = (pos_q >= POS_W'(MAX_LENGTH));
  assign pos_new = pos_sat ? POS_W'(MAX_LENGTH) : (pos_q + POS_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pos_ovf_q <= 1'b0;
    end else if (accept) begin
      pos_q     <= last_item_i ? '0 : pos_new;
      pos_ovf_q <= last_item_i ? 1'b0 : (pos_ovf_q | pos_sat);
    end
  end

  // Stage 1: the request's flags and the two positions it needs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q.last    <= last_item_i;
      s1_flags_q.pos_ovf <= pos_ovf_q | pos_sat;
      pk_q               <= pk;
      pk1_q              <= pk1;
    end
  end

  // Head of the row: the new entry always goes into slot 0
  assign name_c[0]  = key;
  assign pos_c[0]   = pos_new;
  assign valid_c[0] = 1'b1;
  assign found_c[0] = 1'b0;

  // Move-to-front row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ekdw_cell #(
      .KEY_W (KEY_W),
      .POS_W (POS_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .upd_i        (accept),
      .clr_i        (last_item_i),
      .key_i        (key),
      .found_i      (found_c[g]),
      .prev_name_i  (name_c[g]),
      .prev_pos_i   (pos_c[g]),
      .prev_valid_i (valid_c[g]),
      .name_o       (name_c[g+1]),
      .pos_o        (pos_c[g+1]),
      .valid_o      (valid_c[g+1]),
      .found_o      (found_c[g+1]),
      .nxt_pos_o    (nxt_pos[g])
    );
  end

  // Pick positions of slots k-1 and k as they stand after this update
  always_comb begin
    pk  = '0;
    pk1 = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_lo == IDX_W'(i)) begin
        pk = pk | nxt_pos[i];
      end
      if (slot_hi == IDX_W'(i)) begin
        pk1 = pk1 | nxt_pos[i];
      end
    end
  end

  ekdw_accum #(
    .POS_W (POS_W)
  ) u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .s1_valid_i      (s1_valid_q),
    .s1_flags_i      (s1_flags_q),
    .pk_i            (pk_q),
    .pk1_i           (pk1_q),
    .out_valid_o     (out_valid_o),
    .running_total_o (running_total_o),
    .total_final_o   (total_final_o),
    .overflow_o      (overflow_o)
  );

endmodule

/* rtl/ekdw_cell.sv */
// One entry of the move-to-front table. Shifts in its upper neighbor's
// entry unless a match was found in an earlier (more recent) cell.
module ekdw_cell #(
  parameter int KEY_W = 32,
  parameter int POS_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,         // request accepted this cycle
  input  logic             clr_i,         // request is the last of its sequence
  input  logic [KEY_W-1:0] key_i,         // searched name, broadcast
  input  logic             found_i,       // hit in an earlier cell
  input  logic [KEY_W-1:0] prev_name_i,
  input  logic [POS_W-1:0] prev_pos_i,
  input  logic             prev_valid_i,
  output logic [KEY_W-1:0] name_o,
  output logic [POS_W-1:0] pos_o,         // zero when the entry is empty
  output logic             valid_o,
  output logic             found_o,
  output logic [POS_W-1:0] nxt_pos_o      // position after this update, zero if empty
);

  logic [KEY_W-1:0] name_q;
  logic [POS_W-1:0] pos_q;
  logic             valid_q;
  logic             match;
  logic             load;
  logic             nxt_valid;

  // Compare and hand the hit flag down the row
  assign match   = valid_q && (name_q == key_i);
  assign found_o = found_i | match;
  assign load    = upd_i && !found_i;

  // Entry as it stands after this cycle's update, before any clearing
  assign nxt_valid = load ? prev_valid_i : valid_q;
  assign nxt_pos_o = !nxt_valid ? '0 : (load ? prev_pos_i : pos_q);

  // Valid flag; the whole table empties after the last request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_i && clr_i) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= prev_valid_i;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      name_q <= prev_name_i;
      pos_q  <= prev_pos_i;
    end
  end

  assign name_o  = name_q;
  assign pos_o   = valid_q ? pos_q : '0;
  assign valid_o = valid_q;

endmodule

/* rtl/ekdw_accum.sv */
// Difference stage and saturating accumulator with the output register.
module ekdw_accum
  import ekdw_pkg::*;
#(
  parameter int POS_W = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,       // pipeline moves this cycle
  input  logic               s1_valid_i,
  input  item_flags_t        s1_flags_i,
  input  logic [POS_W-1:0]   pk_i,        // position at slot k-1
  input  logic [POS_W-1:0]   pk1_i,       // position at slot k
  output logic               out_valid_o,
  output logic [TOTAL_W-1:0] running_total_o,
  output logic               total_final_o,
  output logic               overflow_o
);

  logic               s2_valid_q;
  item_flags_t        s2_flags_q;
  logic [POS_W-1:0]   add_q;
  logic [POS_W-1:0]   diff;

  logic [TOTAL_W-1:0] acc_q;
  logic               ovf_q;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] total_out_q;
  logic               final_out_q;
  logic               ovf_out_q;

  logic [TOTAL_W:0]   sum;
  logic               sat;
  logic [TOTAL_W-1:0] new_total;
  logic               new_ovf;

  // Runs ending at this request
  assign diff = (pk_i >= pk1_i) ? (pk_i - pk1_i) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_valid_i) begin
      add_q      <= diff;
      s2_flags_q <= s1_flags_i;
    end
  end

  // Saturating add
  assign sum       = {1'b0, acc_q} + (TOTAL_W + 1)'(add_q);
  assign sat       = sum[TOTAL_W];
  assign new_total = sat ? '1 : sum[TOTAL_W-1:0];
  assign new_ovf   = ovf_q | s2_flags_q.pos_ovf | sat;

  // Running state, cleared after the last request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        acc_q <= s2_flags_q.last ? '0 : new_total;
        ovf_q <= s2_flags_q.last ? 1'b0 : new_ovf;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (adv_i && s2_valid_q) begin
      total_out_q <= new_total;
      final_out_q <= s2_flags_q.last;
      ovf_out_q   <= new_ovf;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign running_total_o = total_out_q;
  assign total_final_o   = final_out_q;
  assign overflow_o      = ovf_out_q;

endmodule

/* rtl/ekdw_checker.sv */
`include "exact_k_distinct_window_counter_defines.svh"

// Port-level checks on the counter.
module ekdw_checker
  import ekdw_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [NAME_CODE_W-1:0] name_code_i,
  input logic                   last_item_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [TOTAL_W-1:0]     running_total_o,
  input logic                   total_final_o,
  input logic                   overflow_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [TARGET_W-1:0]    cfg_data_i
);

  // A stalled result holds
  `EKDW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(running_total_o), "stalled result changed")

  // An empty output slot never blocks the input
  `EKDW_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")

  // Within a sequence, back-to-back totals never decrease
  `EKDW_ASSERT_IMP(a_total_mono, clk_i, rst_ni, out_valid_o && $past(out_valid_o && !out_stall_i && !total_final_o), running_total_o >= $past(running_total_o), "running total decreased")

  // Overflow sticks until the sequence ends
  `EKDW_ASSERT_IMP(a_ovf_sticky, clk_i, rst_ni, out_valid_o && $past(out_valid_o && !out_stall_i && !total_final_o && overflow_o), overflow_o, "overflow flag dropped mid-sequence")

endmodule

bind exact_k_distinct_window_counter ekdw_checker u_ekdw_checker (.*);

/* dv/tb_exact_k_distinct_window_counter.sv */
module tb_exact_k_distinct_window_counter;
  import ekdw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = MAX_DISTINCT_DEF + 1;
  localparam int RANDOM_ITEMS = 1750;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [NAME_CODE_W-1:0] name_code_i = '0;
  logic                   last_item_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [TOTAL_W-1:0]     running_total_o;
  logic                   total_final_o;
  logic                   overflow_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [TARGET_W-1:0]    cfg_data_i = '0;

  // one expected result per accepted request
  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               is_last;
    logic               ovf;
  } total_entry_t;

  // Move-to-front predictor of the exact-k run total plus result checking
  class k_window_tracker;
    logic [NAME_CODE_W-1:0] mtf_names[TABLE_DEPTH];
    int unsigned            mtf_pos[TABLE_DEPTH];
    bit                     mtf_valid[TABLE_DEPTH];
    int unsigned            seq_pos;
    logic [TOTAL_W-1:0]     run_total;
    bit                     sat_seen;
    logic [TARGET_W-1:0]    target_raw;
    total_entry_t           expected_totals[$];
    int unsigned            mismatches;
    int unsigned            results_seen;

    function new();
      target_raw   = TARGET_RESET;
      mismatches   = 0;
      results_seen = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        mtf_names[i] = '0;
        mtf_pos[i]   = 0;
        mtf_valid[i] = 1'b0;
      end
      seq_pos   = 0;
      run_total = '0;
      sat_seen  = 1'b0;
    endfunction

    function void set_target(logic [TARGET_W-1:0] value);
      target_raw = value;
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction

    // Accepted request: update the table and queue the expected total
    function void take_name(logic [NAME_CODE_W-1:0] name, logic is_last);
      int unsigned        k;
      int                 hit;
      int                 i;
      bit                 found;
      logic [TOTAL_W-1:0] pk;
      logic [TOTAL_W-1:0] pk1;
      logic [TOTAL_W-1:0] add;
      logic [TOTAL_W-1:0] total_max;
      total_entry_t       entry;

      total_max = '1;
      k = 32'(target_raw);
      if (k < 1) k = 1;
      if (k > MAX_DISTINCT_DEF) k = MAX_DISTINCT_DEF;

      // position sticks at the max length once reached
      if (seq_pos >= MAX_LENGTH_DEF) begin
        seq_pos  = MAX_LENGTH_DEF;
        sat_seen = 1'b1;
      end else begin
        seq_pos++;
      end

      // a miss shifts the whole table, dropping the oldest entry
      hit   = TABLE_DEPTH - 1;
      found = 1'b0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (!found && mtf_valid[i] && mtf_names[i] == name) begin
          hit   = i;
          found = 1'b1;
        end
      end
      for (i = hit; i > 0; i--) begin
        mtf_names[i] = mtf_names[i-1];
        mtf_pos[i]   = mtf_pos[i-1];
        mtf_valid[i] = mtf_valid[i-1];
      end
      mtf_names[0] = name;
      mtf_pos[0]   = seq_pos;
      mtf_valid[0] = 1'b1;

      // runs ending here with exactly k names: p_k - p_(k+1)
      pk  = mtf_valid[k-1] ? TOTAL_W'(mtf_pos[k-1]) : '0;
      pk1 = mtf_valid[k]   ? TOTAL_W'(mtf_pos[k])   : '0;
      add = (pk >= pk1) ? pk - pk1 : '0;

      if (add > total_max - run_total) begin
        run_total = total_max;
        sat_seen  = 1'b1;
      end else begin
        run_total = run_total + add;
      end

      entry.total   = run_total;
      entry.is_last = is_last;
      entry.ovf     = sat_seen;
      expected_totals.push_back(entry);

      if (is_last) clear_sequence();
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    endtask

    // Accepted result: compare against the oldest pending expectation
    task check_total(logic [TOTAL_W-1:0] total, logic is_last, logic ovf);
      total_entry_t want;
      results_seen++;
      if (expected_totals.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, total %0d", total));
      end else begin
        want = expected_totals.pop_front();
        if (total !== want.total)
          flag_mismatch($sformatf("running_total %0d, want %0d", total, want.total));
        if (is_last !== want.is_last)
          flag_mismatch($sformatf("total_final %b, want %b", is_last, want.is_last));
        if (ovf !== want.ovf)
          flag_mismatch($sformatf("overflow %b, want %b", ovf, want.ovf));
      end
    endtask
  endclass

  k_window_tracker tracker = new();

  int unsigned sent_count  = 0;
  int unsigned burst_left  = 0;
  bit          full_rate   = 1'b0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;

  exact_k_distinct_window_counter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .name_code_i    (name_code_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .running_total_o(running_total_o),
    .total_final_o  (total_final_o),
    .overflow_o     (overflow_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_total(running_total_o, total_final_o, overflow_o);
  end

  // receiver stall: random density, re-picked when its random countdown runs out
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 20;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // hold the request channel idle for the wait given by n
  task automatic idle_cycles(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // present one request and wait until it is taken
  task automatic drive_request(logic [NAME_CODE_W-1:0] name, logic is_last);
    in_valid_i  <= 1'b1;
    name_code_i <= name;
    last_item_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_name(name, is_last);
  endtask

  // sender in bursts with random gaps between them
  task automatic push_name(logic [NAME_CODE_W-1:0] name, logic is_last);
    if (!full_rate && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 12));
    end
    if (burst_left > 0) burst_left--;
    drive_request(name, is_last);
    sent_count++;
  endtask

  // k is only written with nothing in flight
  task automatic write_target(logic [TARGET_W-1:0] value);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_target(value);
  endtask

  // names from a small pool so runs of exactly k names show up; some noise
  task automatic random_sequence(int unsigned len, int unsigned pool_sz, bit close);
    logic [NAME_CODE_W-1:0] pool[$];
    logic [NAME_CODE_W-1:0] name;
    logic                   is_last;
    int unsigned            i;
    for (i = 0; i < pool_sz; i++) begin
      // near-miss names: one bit away from a pool neighbor
      if (i > 0 && $urandom_range(3) == 0)
        pool.push_back(pool[i-1] ^ (32'h1 << $urandom_range(31)));
      else
        pool.push_back($urandom());
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) name = $urandom();
      else name = pool[$urandom_range(pool_sz - 1)];
      is_last = close && (i == len - 1);
      // occasional early end breaks the sequence short
      if ($urandom_range(99) == 0) is_last = 1'b1;
      push_name(name, is_last);
    end
  endtask

  initial begin
    int unsigned                 i;
    int unsigned                 k_eff;
    int unsigned                 n_seq;
    logic [TARGET_W-1:0]         k_raw;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of k, name extremes, a repeat
    push_name(32'h0000_0000, 1'b0);
    push_name(32'h0000_0000, 1'b0);
    push_name(32'hFFFF_FFFF, 1'b1);

    // k of zero acts as one; names one bit apart are distinct
    write_target('0);
    push_name(32'hAAAA_AAAA, 1'b0);
    push_name(32'h5555_5555, 1'b0);
    push_name(32'hAAAA_AAAA, 1'b0);
    push_name(32'hAAAA_AAAB, 1'b0);

    // k changed mid-sequence, above the max; fill and overflow the table
    write_target('1);
    for (i = 0; i < TABLE_DEPTH; i++) push_name(32'h0000_0100 + i, 1'b0);
    push_name(32'hAAAA_AAAA, 1'b1);

    // random phases, each with its own k
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      case ($urandom_range(7))
        0:       k_raw = TARGET_W'(0);
        1:       k_raw = TARGET_W'(1);
        2:       k_raw = TARGET_W'(2);
        3:       k_raw = TARGET_W'(MAX_DISTINCT_DEF);
        4:       k_raw = TARGET_W'(MAX_DISTINCT_DEF + 1);
        5:       k_raw = '1;
        default: k_raw = TARGET_W'($urandom_range(0, (1 << TARGET_W) - 1));
      endcase
      write_target(k_raw);
      k_eff = (k_raw == 0) ? 1 : (k_raw > MAX_DISTINCT_DEF) ? MAX_DISTINCT_DEF : k_raw;
      full_rate = ($urandom_range(4) == 0);
      n_seq = $urandom_range(1, 4);
      for (i = 0; i < n_seq; i++) begin
        // last sequence of a phase is sometimes left open across the k change
        random_sequence(($urandom_range(9) == 0) ? $urandom_range(50, 300)
                                                 : $urandom_range(1, 48),
                        k_eff + $urandom_range(0, k_eff + 2),
                        (i != n_seq - 1) || ($urandom_range(2) != 0));
      end
    end
    full_rate = 1'b0;
    in_valid_i <= 1'b0;

    // drain, then wait on for anything stray
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("exact_k_distinct_window_counter: match");
    end else begin
      $display("exact_k_distinct_window_counter: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("exact_k_distinct_window_counter: mismatch");
    $finish;
  end

endmodule
